// ----- rtl/wms_pkg.sv -----
// shared widths, defaults, register indexes and the max tree for the suppression block
package wms_pkg;

	localparam int WMS_WINDOW    = 7;
	localparam int WMS_MAX_WIDTH = 1024;

	localparam int RESP_W = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 12;
	localparam int ROW_W  = 12;
	localparam int CFG_W  = 12;
	localparam int IDX_W  = 1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// widest set of values fed to one max tree (window side is at most 15)
	localparam int MAX_VALS = 16;

	typedef logic [MAX_VALS-1:0][RESP_W-1:0] max_vec_t;

	// one window column as seen by the cell row
	typedef struct packed {
		logic [RESP_W-1:0] peak;
		logic [RESP_W-1:0] mid;
	} column_t;

	// pairwise reduction, four levels deep
	function automatic logic [RESP_W-1:0] max_tree(input max_vec_t v);
		max_vec_t t;
		t = v;
		for (int lvl = 0; lvl < 4; lvl++) begin
			for (int i = 0; i < MAX_VALS / 2; i++) begin
				t[i] = (t[2*i] > t[2*i+1]) ? t[2*i] : t[2*i+1];
			end
		end
		return t[0];
	endfunction

endpackage

// ----- rtl/window_max_suppression_core.sv -----
// Streaming non-maximum suppression over a square window of 8-bit responses.
// Pixels enter in raster order on the input channel (in_valid / in_stall);
// a transfer happens at a clock edge with in_valid high and in_stall low.
// Once a centre lies at least half a window from the top and left edges,
// each pixel yields one result on the output channel (out_valid / out_stall):
// the centre's row and column, whether it equals its window maximum (plateau
// ties all count) and the kept value. Earlier pixels give no result.
// frame_done marks the last interior centre of a frame.
// A pixel's result is registered after the read stage and the cell row.
// Throughput: one pixel per clock unless the receiver stalls, bounded by the
// single-port line stores: per pixel, all are read at the current column and the
// current slot's store is written. The pipeline holds one pixel in the read stage,
// one pending window in the cell row and one result in the output register; when
// the receiver stalls these fill and in_stall rises, and nothing is dropped.
// Reset clears the counters, the cell row and the pipeline, and loads the
// default 640 x 480 frame size; the line stores are not cleared and need no
// sweep, as every entry is written before a result depends on it.
// frame_width and frame_height are written through write_en / reg_index / write_data;
// the user must write them only while the block is idle; the block does not check it.
module window_max_suppression_core import wms_pkg::*; #(
	parameter int WINDOW    = WMS_WINDOW,
	parameter int MAX_WIDTH = WMS_MAX_WIDTH,
	localparam int COL_W    = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_en,
	input  logic [IDX_W-1:0]  reg_index,
	input  logic [CFG_W-1:0]  write_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [RESP_W-1:0] response,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROW_W-1:0]  centre_row,
	output logic [COL_W-1:0]  centre_col,
	output logic              is_maximum,
	output logic [RESP_W-1:0] kept_value,
	output logic              frame_done
);

	localparam int HALF   = (WINDOW - 1) / 2;
	localparam int SPAN   = 2 * HALF + 1;
	localparam int NLINES = SPAN - 1;
	localparam int SW     = (NLINES > 1) ? $clog2(NLINES) : 1;
	localparam int EW     = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

	// configuration
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (write_en) begin
			unique case (reg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= write_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= write_data[FH_W-1:0];
			endcase
		end
	end

	// handshake chain
	logic accept, adv1, out_load, ready1, ready2;
	logic v1_q, v2_q, ov_q;

	assign out_load = v2_q & (~ov_q | ~out_stall);
	assign ready2   = ~v2_q | out_load;
	assign adv1     = v1_q & ready2;
	assign ready1   = ~v1_q | adv1;
	assign accept   = in_valid & ready1;
	assign in_stall = ~ready1;

	// input position counters
	logic [COL_W-1:0] col_q, ic_cur;
	logic [ROW_W-1:0] row_q, ir_cur;
	logic [SW-1:0]    slot_q, slot_cur;
	logic [EW-1:0]    w_eff, col_next;
	logic [FH_W-1:0]  h_eff;
	logic [ROW_W:0]   row_next;
	logic             emit, done;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(frame_width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;

		ic_cur = (EW'(col_q) >= w_eff) ? '0 : col_q;
		if (row_q >= h_eff) begin
			ir_cur   = '0;
			slot_cur = '0;
		end else begin
			ir_cur   = row_q;
			slot_cur = slot_q;
		end

		col_next = EW'(ic_cur) + EW'(1);
		row_next = {1'b0, ir_cur} + (ROW_W+1)'(1);
		emit     = (ir_cur >= ROW_W'(SPAN - 1)) && (ic_cur >= COL_W'(SPAN - 1));
		done     = (row_next == (ROW_W+1)'(h_eff)) && (col_next == w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (col_next >= w_eff) begin
				col_q <= '0;
				if (row_next >= (ROW_W+1)'(h_eff)) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_next[ROW_W-1:0];
					slot_q <= (slot_cur == SW'(NLINES - 1)) ? '0 : slot_cur + SW'(1);
				end
			end else begin
				col_q  <= col_next[COL_W-1:0];
				row_q  <= ir_cur;
				slot_q <= slot_cur;
			end
		end
	end

	// line stores, one per stored row
	logic [NLINES-1:0][RESP_W-1:0] rd_data;

	for (genvar k = 0; k < NLINES; k++) begin : g_line
		wms_line_ram #(
			.DEPTH (MAX_WIDTH),
			.AW    (COL_W)
		) u_line_ram (
			.clk     (clk),
			.en      (accept),
			.we      (accept && (slot_cur == SW'(k))),
			.addr    (ic_cur),
			.wr_data (response),
			.rd_data (rd_data[k])
		);
	end

	// read stage
	logic [RESP_W-1:0] px_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SW-1:0]     slot_s1;
	logic              emit_s1, done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (ready1) begin
			v1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= response;
			row_s1  <= ir_cur - ROW_W'(HALF);
			col_s1  <= ic_cur - COL_W'(HALF);
			slot_s1 <= slot_cur;
			emit_s1 <= emit;
			done_s1 <= done;
		end
	end

	// new column: peak over stored rows and the incoming pixel, middle row by slot rotation
	max_vec_t  col_vals;
	logic [SW:0] mid_sum, mid_idx;
	column_t   new_col;

	always_comb begin
		col_vals = '0;
		for (int k = 0; k < NLINES; k++) begin
			col_vals[k] = rd_data[k];
		end
		col_vals[NLINES] = px_s1;
		mid_sum = {1'b0, slot_s1} + (SW+1)'(HALF);
		mid_idx = (mid_sum >= (SW+1)'(NLINES)) ? mid_sum - (SW+1)'(NLINES) : mid_sum;
		new_col.peak = max_tree(col_vals);
		new_col.mid  = rd_data[mid_idx[SW-1:0]];
	end

	// cell row, oldest column at index zero
	column_t cell_d [SPAN];
	column_t cell_q [SPAN];

	for (genvar j = 0; j < SPAN; j++) begin : g_cell
		if (j == SPAN - 1) begin : g_head
			assign cell_d[j] = new_col;
		end else begin : g_link
			assign cell_d[j] = cell_q[j+1];
		end
		wms_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (adv1),
			.d      (cell_d[j]),
			.q      (cell_q[j])
		);
	end

	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv1) begin
			v2_q <= emit_s1;
		end else if (out_load) begin
			v2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			done_s2 <= done_s1;
		end
	end

	// window judgement
	max_vec_t          win_vals;
	logic [RESP_W-1:0] win_max, centre;
	logic              hit;

	always_comb begin
		win_vals = '0;
		for (int j = 0; j < SPAN; j++) begin
			win_vals[j] = cell_q[j].peak;
		end
		win_max = max_tree(win_vals);
		centre  = cell_q[HALF].mid;
		hit     = (centre == win_max);
	end

	// output register
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic              out_max_q, out_done_q;
	logic [RESP_W-1:0] out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= row_s2;
			out_col_q  <= col_s2;
			out_max_q  <= hit;
			out_val_q  <= hit ? centre : '0;
			out_done_q <= done_s2;
		end
	end

	assign out_valid  = ov_q;
	assign centre_row = out_row_q;
	assign centre_col = out_col_q;
	assign is_maximum = out_max_q;
	assign kept_value = out_val_q;
	assign frame_done = out_done_q;

endmodule

// ----- rtl/wms_line_ram.sv -----
// one line store: single address, read-before-write, registered read data
module wms_line_ram import wms_pkg::*; #(
	parameter int DEPTH = WMS_MAX_WIDTH,
	parameter int AW    = $clog2(WMS_MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [RESP_W-1:0] wr_data,
	output logic [RESP_W-1:0] rd_data
);

	logic [RESP_W-1:0] mem [DEPTH];
	logic [RESP_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= mem[addr];
		end
		if (we) begin
			mem[addr] <= wr_data;
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/wms_cell.sv -----
// one window column cell: holds the column peak and middle value, takes its right neighbour's
module wms_cell import wms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  column_t d,
	output column_t q
);

	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule

// ----- rtl/wms_checker.sv -----
// port-level checks for the suppression core, bound to the top level
module wms_checker import wms_pkg::*; #(
	parameter int WINDOW    = WMS_WINDOW,
	parameter int MAX_WIDTH = WMS_MAX_WIDTH,
	localparam int COL_W    = $clog2(MAX_WIDTH)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ROW_W-1:0]  centre_row,
	input logic [COL_W-1:0]  centre_col,
	input logic              is_maximum,
	input logic [RESP_W-1:0] kept_value
);

	localparam int HALF = (WINDOW - 1) / 2;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(centre_row) && $stable(centre_col)
			&& $stable(kept_value) && $stable(is_maximum))
		else $error("stalled result changed");

	// suppressed centres carry zero
	a_suppressed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_maximum |-> kept_value == '0)
		else $error("suppressed centre with non-zero value");

	// centres within half a window of the top or left edge are never offered
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (centre_row >= ROW_W'(HALF)) && (centre_col >= COL_W'(HALF)))
		else $error("result for a border centre");

endmodule

bind window_max_suppression_core wms_checker #(
	.WINDOW    (WINDOW),
	.MAX_WIDTH (MAX_WIDTH)
) u_wms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.centre_row (centre_row),
	.centre_col (centre_col),
	.is_maximum (is_maximum),
	.kept_value (kept_value)
);
